// ===== hw/rtl/refcounted_page_allocator_top_defines.svh =====
// Assertion macros used by the allocator's checker.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold later than the antecedent, not in its own cycle.
`define RPA_ASSERT_TWO(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rpa_pkg.sv =====
package rpa_pkg;

    // Beat and field widths on the ports.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int OP_W        = 2;
    localparam int PAGE_W      = 15;
    localparam int STATUS_W    = 3;
    localparam int CNT_OUT_W   = 8;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INC   = 2'd2,
        OP_DEC   = 2'd3
    } rpa_op_t;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREE_ZERO = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDER     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVER      = 3'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } rpa_state_t;

endpackage

// ===== hw/rtl/refcounted_page_allocator_top.sv =====
// Reference-counted page allocator.
// Input beats on s_tvalid/s_tready/s_tdata carry an operation (allocate, free,
// increment, decrement) and a page index. Every input beat yields exactly one
// result beat on m_tvalid/m_tready/m_tdata with the page, a status code, a
// pooled flag and the page's count after the operation.
// The first usable page is set through cfg_we/cfg_wdata; the user is to
// write it only while the block idles, and the block does not enforce this.
// An accepted beat is executed in S_EXEC and then loaded into the output
// register. The block takes no new operation before the last one is through:
// the count memory is read in the accept cycle and written back in the execute
// cycle, and the next read is only issued after that write has landed.
// Reset: the count memory is swept to zero, one entry per cycle, from entry 0
// to NUM_PAGES-1; s_tready stays low during the sweep. Configuration writes
// are taken during the sweep as well.
// Stall: the block accepts the next beat while a result waits in the output
// register; that beat then holds in its execute cycle until the output
// register is taken, and s_tready stays low meanwhile.
module refcounted_page_allocator_top #(
    parameter int NUM_PAGES  = 32768,
    parameter int COUNT_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: first usable page.
    input  logic                            cfg_we,
    input  logic [rpa_pkg::PAGE_W-1:0]      cfg_wdata,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: op[1:0], page_index[16:2], zero padding[23:17].
    input  logic [rpa_pkg::IN_TDATA_W-1:0]  s_tdata,
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: page[14:0], status[17:15], returned_to_pool[18],
    // count_after[26:19], zero padding[31:27].
    output logic [rpa_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import rpa_pkg::*;

    localparam int PAGE_BITS = $clog2(NUM_PAGES);
    localparam int UW        = $clog2(NUM_PAGES + 1);
    localparam int CMP_W     = (UW > PAGE_W) ? UW : PAGE_W;

    // Memories.
    logic [COUNT_BITS-1:0] count_mem [NUM_PAGES];
    logic [PAGE_BITS-1:0]  stack_mem [NUM_PAGES];

    // Control and state registers.
    rpa_state_t            state_reg, state_next;
    logic [PAGE_BITS-1:0]  clr_addr_reg;
    logic [PAGE_W-1:0]     first_page_reg;
    logic [UW-1:0]         depth_reg, depth_next;
    logic [UW-1:0]         untouched_reg, untouched_next;
    rpa_op_t               op_reg;
    logic [PAGE_W-1:0]     idx_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic [PAGE_BITS-1:0]  stk_rd_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [PAGE_W-1:0]     out_page_reg, out_page_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic                  out_pooled_reg, out_pooled_next;
    logic [CNT_OUT_W-1:0]  out_cnt_reg, out_cnt_next;

    // Handshake and datapath signals.
    logic                  in_fire;
    logic                  exec_fire;
    logic                  out_free;
    logic [PAGE_W-1:0]     in_idx;
    logic                  cnt_we;
    logic [PAGE_BITS-1:0]  cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  stk_we;
    logic [PAGE_BITS-1:0]  stk_waddr;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic [UW-1:0]         untouched_dec;
    logic                  idx_in_range;

    assign in_idx   = s_tdata[PAGE_W+OP_W-1:OP_W];
    assign out_free = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // Sequencer: clearing sweep, accept, execute.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        exec_fire  = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_addr_reg == PAGE_BITS'(NUM_PAGES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    exec_fire  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sweep address for the post-reset clear of the count memory.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (state_reg == S_CLEAR) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_page_reg <= '0;
        end else if (cfg_we) begin
            first_page_reg <= cfg_wdata;
        end
    end

    // Capture the operation of an accepted beat.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg  <= rpa_op_t'(s_tdata[OP_W-1:0]);
            idx_reg <= in_idx;
        end
    end

    // Execute: decide the result and the write-backs from the read data.
    assign cnt_dec       = cnt_rd_reg - 1'b1;
    assign untouched_dec = untouched_reg - 1'b1;
    assign idx_in_range  = CMP_W'(idx_reg) < CMP_W'(NUM_PAGES);

    always_comb begin
        depth_next      = depth_reg;
        untouched_next  = untouched_reg;
        cnt_we          = 1'b0;
        cnt_waddr       = PAGE_BITS'(idx_reg);
        cnt_wdata       = cnt_dec;
        stk_we          = 1'b0;
        stk_waddr       = PAGE_BITS'(depth_reg);
        out_page_next   = idx_reg;
        out_status_next = ST_OK;
        out_pooled_next = 1'b0;
        out_cnt_next    = '0;
        if (op_reg == OP_ALLOC) begin
            priority if (depth_reg != '0) begin
                // Reuse the most recently freed page.
                depth_next    = depth_reg - 1'b1;
                cnt_we        = 1'b1;
                cnt_waddr     = stk_rd_reg;
                cnt_wdata     = COUNT_BITS'(1);
                out_page_next = PAGE_W'(stk_rd_reg);
                out_cnt_next  = CNT_OUT_W'(1);
            end else if (CMP_W'(untouched_reg) > CMP_W'(first_page_reg)) begin
                // Hand out the next never-used page from the top.
                untouched_next = untouched_dec;
                cnt_we         = 1'b1;
                cnt_waddr      = PAGE_BITS'(untouched_dec);
                cnt_wdata      = COUNT_BITS'(1);
                out_page_next  = PAGE_W'(untouched_dec);
                out_cnt_next   = CNT_OUT_W'(1);
            end else begin
                out_page_next   = '0;
                out_status_next = ST_EMPTY;
            end
        end else if (idx_in_range) begin
            unique case (op_reg)
                OP_FREE: begin
                    if (cnt_rd_reg == '0) begin
                        out_status_next = ST_FREE_ZERO;
                    end else begin
                        cnt_we       = 1'b1;
                        out_cnt_next = CNT_OUT_W'(cnt_dec);
                        // Pool the page when its last reference goes away.
                        if (cnt_dec == '0 && depth_reg < UW'(NUM_PAGES)) begin
                            stk_we          = 1'b1;
                            depth_next      = depth_reg + 1'b1;
                            out_pooled_next = 1'b1;
                        end
                    end
                end
                OP_INC: begin
                    if (cnt_rd_reg == '1) begin
                        out_status_next = ST_OVER;
                        out_cnt_next    = CNT_OUT_W'(cnt_rd_reg);
                    end else begin
                        cnt_we       = 1'b1;
                        cnt_wdata    = cnt_rd_reg + 1'b1;
                        out_cnt_next = CNT_OUT_W'(cnt_rd_reg + 1'b1);
                    end
                end
                OP_DEC: begin
                    if (cnt_rd_reg == '0) begin
                        out_status_next = ST_UNDER;
                    end else begin
                        cnt_we       = 1'b1;
                        out_cnt_next = CNT_OUT_W'(cnt_dec);
                    end
                end
                default: begin
                    out_status_next = ST_OK;
                end
            endcase
        end
    end

    // Pool depth and never-used page pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= '0;
            untouched_reg <= UW'(NUM_PAGES);
        end else if (exec_fire) begin
            depth_reg     <= depth_next;
            untouched_reg <= untouched_next;
        end
    end

    // Count memory: cleared by the sweep, read at accept, written at execute.
    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR) begin
            count_mem[clr_addr_reg] <= '0;
        end else if (exec_fire && cnt_we) begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (in_fire) begin
            cnt_rd_reg <= count_mem[PAGE_BITS'(in_idx)];
        end
    end

    // Freed-page stack: top entry read at accept, pushed at execute.
    always_ff @(posedge aclk) begin
        if (exec_fire && stk_we) begin
            stack_mem[stk_waddr] <= PAGE_BITS'(idx_reg);
        end
        if (in_fire) begin
            stk_rd_reg <= stack_mem[PAGE_BITS'(depth_reg - 1'b1)];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            out_page_reg   <= out_page_next;
            out_status_reg <= out_status_next;
            out_pooled_reg <= out_pooled_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - PAGE_W - STATUS_W - 1 - CNT_OUT_W){1'b0}},
                       out_cnt_reg, out_pooled_reg, out_status_reg, out_page_reg};

endmodule

// ===== hw/rtl/rpa_checker.sv =====
`include "refcounted_page_allocator_top_defines.svh"

module rpa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rpa_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import rpa_pkg::*;

    logic [STATUS_W-1:0] status;
    logic                pooled;
    logic [CNT_OUT_W-1:0] cnt_after;

    assign status    = m_tdata[PAGE_W+STATUS_W-1:PAGE_W];
    assign pooled    = m_tdata[PAGE_W+STATUS_W];
    assign cnt_after = m_tdata[PAGE_W+STATUS_W+CNT_OUT_W:PAGE_W+STATUS_W+1];

    // A stalled result beat keeps its payload.
    `RPA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // One operation at a time: no accept right after an accept.
    `RPA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input accepted during execute")

    // An accepted beat is always followed by a high m_tvalid.
    `RPA_ASSERT_TWO(a_result_shows, aclk, aresetn, s_tvalid && s_tready, m_tvalid, "no result after an accepted beat")

    // A pooled page always leaves with a zero count and an ok status.
    `RPA_ASSERT_SAME(a_pooled_zero, aclk, aresetn, m_tvalid && pooled, (cnt_after == '0) && (status == ST_OK), "pooled page with nonzero count")

endmodule

bind refcounted_page_allocator_top rpa_checker u_rpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
